### rtl/sssp_pkg.sv
// Package: shared constants for the shortest-path unit.
package sssp_pkg;
	localparam int MaxVerticesDef = 64;
	localparam int WeightBitsDef = 25;
	localparam int VIdxBits = 6;
	localparam int DistBits = 32;
	localparam int PredBits = 7;
	localparam int CountBits = 7;
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_RUN = 1'b1;
endpackage

### rtl/sssp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module sssp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

### rtl/single_source_shortest_paths_unit.sv
// Top level: dense-graph Dijkstra engine with weight matrix and result stream.
// Write transactions (kind 0) store one weight. A run transaction (kind 1) for n active
// vertices first clears the distance and predecessor RAMs over n entries; each settled
// vertex then costs a scan of the n vertices for the nearest unsettled vertex (one RAM
// read ahead) plus a sweep over its matrix row (one edge a cycle through one shared
// adder/compare); one last scan finds nothing, and each result then passes through a read
// state and an emit state, the emit state waiting while the output stalls. No new input
// is taken during a run. The output register lets the final result wait while the next
// input is accepted.
module single_source_shortest_paths_unit
	import sssp_pkg::*;
#(
	parameter int MAX_VERTICES = MaxVerticesDef,
	parameter int WEIGHT_BITS = WeightBitsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [CountBits-1:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [(12+WEIGHT_BITS+7)/8*8-1:0] s_tdata, // from_vertex, to_vertex, edge_weight
	input  logic        s_tuser,                       // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,                       // vertex_index, path_distance, predecessor
	output logic        m_tlast                        // last_item
);
	localparam int AB = $clog2(MAX_VERTICES);
	localparam int CapI = MAX_VERTICES < 64 ? MAX_VERTICES : 64;
	localparam logic [CountBits-1:0] Cap = CountBits'(CapI);
	localparam logic [WEIGHT_BITS-1:0] NoEdge = '1;
	localparam int SumBits = (WEIGHT_BITS > DistBits ? WEIGHT_BITS : DistBits) + 1;
	localparam logic [SumBits-1:0] DistMax = SumBits'({DistBits{1'b1}});

	typedef enum logic [2:0] {
		ST_IDLE, ST_INIT, ST_SCAN0, ST_SCAN, ST_ROWRD, ST_RELAX, ST_EMITRD, ST_EMIT
	} state_t;

	state_t state_q;
	logic [CountBits-1:0] vcount_q, n_q;
	logic [CountBits-1:0] start_q;
	logic [CountBits-1:0] idx_q;
	logic [AB-1:0] u_q, pick_q, col_q;
	logic found_q;
	logic [DistBits-1:0] pick_d_q, du_q;
	logic out_full_q;
	logic [47:0] out_data_q;
	logic out_last_q;

	logic [VIdxBits-1:0] in_from, in_to;
	logic [WEIGHT_BITS-1:0] in_w, rd_w;
	logic acc, we;
	logic [2*AB-1:0] raddr;
	logic [SumBits-1:0] sum;
	logic [DistBits-1:0] sat;
	logic [AB-1:0] iv;
	logic vr_we, pr_we;
	logic [AB-1:0] vr_waddr;
	logic [DistBits:0] vr_wdata, vr_rdata;
	logic [PredBits-1:0] pr_wdata, pr_rdata;
	logic [DistBits-1:0] rd_dist, init_dist;
	logic rd_settled, cand, relax_upd, last_col, out_load;

	assign in_from = s_tdata[5:0];
	assign in_to = s_tdata[11:6];
	assign in_w = s_tdata[12 +: WEIGHT_BITS];
	assign s_tready = (state_q == ST_IDLE);
	assign acc = s_tvalid && s_tready;
	assign we = acc && (s_tuser == KIND_WRITE) && (int'(in_from) < MAX_VERTICES)
		&& (int'(in_to) < MAX_VERTICES);
	assign iv = AB'(idx_q);
	// row address: u's row, column from sweep index (one ahead)
	assign raddr = {u_q, iv};
	assign m_tvalid = out_full_q;
	assign m_tdata = out_data_q;
	assign m_tlast = out_last_q;

	sssp_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(1 << (2*AB))) u_wram (
		.clk(clk), .we(we), .waddr({AB'(in_from), AB'(in_to)}), .wdata(in_w),
		.raddr(raddr), .rdata(rd_w));

	// per-vertex word: settled mark over best distance
	sssp_ram #(.WIDTH(DistBits+1), .DEPTH(MAX_VERTICES)) u_vram (
		.clk(clk), .we(vr_we), .waddr(vr_waddr), .wdata(vr_wdata),
		.raddr(iv), .rdata(vr_rdata));

	sssp_ram #(.WIDTH(PredBits), .DEPTH(MAX_VERTICES)) u_pram (
		.clk(clk), .we(pr_we), .waddr(vr_waddr), .wdata(pr_wdata),
		.raddr(iv), .rdata(pr_rdata));

	assign rd_settled = vr_rdata[DistBits];
	assign rd_dist = vr_rdata[DistBits-1:0];
	assign init_dist = (start_q == idx_q) ? '0 : '1;

	// shared saturating adder and compares
	assign sum = SumBits'(du_q) + SumBits'(rd_w);
	assign sat = (sum > DistMax) ? '1 : sum[DistBits-1:0];
	assign cand = !rd_settled && (rd_dist < pick_d_q);
	assign relax_upd = !rd_settled && (rd_w != NoEdge) && (sat < rd_dist);
	assign last_col = (CountBits'(col_q) == n_q - CountBits'(1));
	assign out_load = (state_q == ST_EMIT) && (!out_full_q || m_tready);

	// vertex RAM writes: clear, settle, relax
	always_comb begin
		vr_we = 1'b0;
		pr_we = 1'b0;
		vr_waddr = iv;
		vr_wdata = '0;
		pr_wdata = '1;
		case (state_q)
			ST_INIT: begin
				vr_we = 1'b1;
				pr_we = 1'b1;
				vr_wdata = {1'b0, init_dist};
			end
			ST_ROWRD: begin
				// the self entry read here is stale but can never improve
				vr_we = 1'b1;
				vr_waddr = u_q;
				vr_wdata = {1'b1, du_q};
			end
			ST_RELAX: begin
				vr_we = relax_upd;
				pr_we = relax_upd;
				vr_waddr = col_q;
				vr_wdata = {1'b0, sat};
				pr_wdata = PredBits'(u_q);
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vcount_q <= 7'd1;
			n_q <= 7'd1;
			start_q <= '0;
			out_full_q <= 1'b0;
			out_data_q <= '0;
			out_last_q <= 1'b0;
			idx_q <= '0;
			u_q <= '0;
			pick_q <= '0;
			col_q <= '0;
			found_q <= 1'b0;
			pick_d_q <= '1;
			du_q <= '0;
		end else begin
			if (cfg_we) vcount_q <= cfg_wdata;
			out_full_q <= out_load || (out_full_q && !m_tready);
			case (state_q)
				ST_IDLE: if (acc && s_tuser == KIND_RUN) begin
					n_q <= (vcount_q == '0) ? CountBits'(1) : (vcount_q > Cap ? Cap : vcount_q);
					start_q <= CountBits'(in_from);
					idx_q <= '0;
					state_q <= ST_INIT;
				end
				ST_INIT: begin
					// clear run state, one entry a cycle
					if (idx_q == n_q - CountBits'(1)) begin
						idx_q <= '0;
						state_q <= ST_SCAN0;
					end else idx_q <= idx_q + CountBits'(1);
				end
				ST_SCAN0: begin
					// first read of the scan issued
					col_q <= iv;
					idx_q <= idx_q + CountBits'(1);
					found_q <= 1'b0;
					pick_d_q <= '1;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (last_col) begin
						idx_q <= '0;
						if (found_q || cand) begin
							u_q <= cand ? col_q : pick_q;
							du_q <= cand ? rd_dist : pick_d_q;
							state_q <= ST_ROWRD;
						end else state_q <= ST_EMITRD;
					end else begin
						if (cand) begin
							pick_d_q <= rd_dist;
							pick_q <= col_q;
							found_q <= 1'b1;
						end
						col_q <= iv;
						idx_q <= idx_q + CountBits'(1);
					end
				end
				ST_ROWRD: begin
					// read for column idx issued; advance
					col_q <= iv;
					idx_q <= idx_q + CountBits'(1);
					state_q <= ST_RELAX;
				end
				ST_RELAX: begin
					if (last_col) begin
						idx_q <= '0;
						state_q <= ST_SCAN0;
					end else begin
						col_q <= iv;
						idx_q <= idx_q + CountBits'(1);
					end
				end
				ST_EMITRD: state_q <= ST_EMIT;
				ST_EMIT: if (out_load) begin
					out_data_q <= {3'b0, pr_rdata, rd_dist, VIdxBits'(idx_q)};
					out_last_q <= (idx_q == n_q - CountBits'(1));
					if (idx_q == n_q - CountBits'(1)) state_q <= ST_IDLE;
					else begin
						idx_q <= idx_q + CountBits'(1);
						state_q <= ST_EMITRD;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

### dv/single_source_shortest_paths_unit_tb.sv
// Testbench for the shortest-path unit: scoreboard against a behavioral Dijkstra predictor.
`timescale 1ns / 100ps

module single_source_shortest_paths_unit_tb;
	import sssp_pkg::*;

	localparam int NV = MaxVerticesDef;
	localparam int WB = WeightBitsDef;
	localparam int DW = (12 + WB + 7) / 8 * 8;
	localparam logic [WB-1:0] NO_EDGE = '1;
	localparam logic [31:0] UNREACHED = '1;
	localparam int WATCHDOG = 200000;

	typedef struct packed {
		logic [PredBits-1:0] pred;
		logic [DistBits-1:0] distance;
		logic [VIdxBits-1:0] vidx;
		logic                last;
	} vertex_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CountBits-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [DW-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic m_tlast;

	single_source_shortest_paths_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	// predictor state
	logic [WB-1:0] edge_weight_mem [NV*NV];
	bit            edge_written [NV*NV];
	int            active_vertices = 1;
	vertex_result_t expected_paths[$];
	int mismatch_count = 0;
	int idle_cycles = 0;
	int items_sent = 0;
	int rx_wait = 0;
	bit rx_enabled = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog: cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("FAIL");
			$finish;
		end
	end

	// Dijkstra over the active vertices, queuing one expectation per vertex
	task automatic predict_paths(input int start);
		logic [31:0] path_dist [NV];
		int pred [NV];
		bit done [NV];
		int pick;
		logic [31:0] pick_d;
		logic [32:0] sum;
		vertex_result_t r;
		for (int i = 0; i < NV; i++) begin
			path_dist[i] = UNREACHED;
			pred[i] = -1;
			done[i] = 0;
		end
		if (start < active_vertices) begin
			path_dist[start] = 0;
			for (int round = 0; round < active_vertices; round++) begin
				pick = active_vertices;
				pick_d = UNREACHED;
				for (int v = 0; v < active_vertices; v++)
					if (!done[v] && path_dist[v] < pick_d) begin
						pick_d = path_dist[v];
						pick = v;
					end
				if (pick >= active_vertices)
					break;
				done[pick] = 1;
				for (int v = 0; v < active_vertices; v++) begin
					if (done[v] || edge_weight_mem[pick*NV+v] == NO_EDGE)
						continue;
					sum = {1'b0, path_dist[pick]} + 33'(edge_weight_mem[pick*NV+v]);
					if (sum > {1'b0, UNREACHED})
						sum = {1'b0, UNREACHED};
					if (sum < {1'b0, path_dist[v]}) begin
						path_dist[v] = sum[31:0];
						pred[v] = pick;
					end
				end
			end
		end
		for (int i = 0; i < active_vertices; i++) begin
			r.vidx = i[VIdxBits-1:0];
			r.distance = path_dist[i];
			r.pred = pred[i][PredBits-1:0];
			r.last = (i == active_vertices - 1);
			expected_paths = {expected_paths, r};
		end
	endtask

	// drive one transaction after a random gap
	task automatic send_item(input logic kind, input int src, input int dst,
			input logic [WB-1:0] w);
		logic [DW-1:0] payload;
		int gap;
		payload = '0;
		payload[5:0] = src[5:0];
		payload[11:6] = dst[5:0];
		payload[12 +: WB] = w;
		gap = $urandom_range(0, 9);
		if (gap != 0) begin
			if (s_tvalid)
				s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= payload;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		if (kind == KIND_WRITE) begin
			edge_weight_mem[src*NV+dst] = w;
			edge_written[src*NV+dst] = 1;
		end else
			predict_paths(src);
	endtask

	// drop valid after the last transaction of a burst
	task automatic release_input();
		if (s_tvalid)
			s_tvalid <= 1'b0;
	endtask

	task automatic write_edge(input int src, input int dst, input logic [WB-1:0] w);
		send_item(KIND_WRITE, src, dst, w);
	endtask

	// load every unwritten entry of the rows a run can reach
	task automatic load_reachable_rows(input int start);
		bit seen [NV];
		int frontier [$];
		int u;
		for (int i = 0; i < NV; i++)
			seen[i] = 0;
		if (start < active_vertices) begin
			seen[start] = 1;
			frontier = {frontier, start};
		end
		while (frontier.size() != 0) begin
			u = frontier.pop_front();
			for (int v = 0; v < active_vertices; v++) begin
				if (!edge_written[u*NV+v])
					write_edge(u, v, NO_EDGE);
				if (edge_weight_mem[u*NV+v] != NO_EDGE && !seen[v]) begin
					seen[v] = 1;
					frontier = {frontier, v};
				end
			end
		end
	endtask

	// only start runs whose reachable rows are fully loaded
	task automatic run_from(input int start);
		load_reachable_rows(start);
		send_item(KIND_RUN, start, $urandom_range(0, 63), WB'($urandom));
	endtask

	task automatic drain_results();
		release_input();
		while (expected_paths.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_vertex_count(input int n);
		drain_results();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= n[CountBits-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		active_vertices = (n < 1) ? 1 : (n > 64 ? 64 : n);
	endtask

	function automatic logic [WB-1:0] random_weight();
		case ($urandom_range(0, 5))
			0: return NO_EDGE;
			1: return '0;
			2: return NO_EDGE - 1;
			default: return WB'($urandom_range(0, 2000));
		endcase
	endfunction

	// result checker with random per-transaction backpressure
	always @(posedge clk) begin
		vertex_result_t e;
		int gap;
		if (m_tvalid && m_tready) begin
			if (expected_paths.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result vertex=%0d", m_tdata[5:0]);
			end else begin
				e = expected_paths.pop_front();
				if (m_tdata[5:0] !== e.vidx || m_tdata[37:6] !== e.distance ||
						m_tdata[44:38] !== e.pred || m_tlast !== e.last) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch exp v=%0d d=%h p=%h l=%b got v=%0d d=%h p=%h l=%b",
							e.vidx, e.distance, e.pred, e.last, m_tdata[5:0],
							m_tdata[37:6], m_tdata[44:38], m_tlast);
				end
			end
		end
		if (rx_enabled) begin
			if (m_tvalid && m_tready) begin
				gap = $urandom_range(0, 9);
				m_tready <= (gap == 0);
				rx_wait <= gap;
			end else if (!m_tready) begin
				m_tready <= (rx_wait <= 1);
				rx_wait <= (rx_wait > 0) ? rx_wait - 1 : 0;
			end
		end
	end

	// directed: extremes, self loops, out-of-range start and writes
	task automatic test_directed();
		set_vertex_count(0);
		run_from(0);
		run_from(63);
		set_vertex_count(4);
		write_edge(0, 1, NO_EDGE - 1);
		write_edge(1, 2, NO_EDGE - 1);
		write_edge(2, 3, NO_EDGE - 1);
		write_edge(0, 0, 0);
		write_edge(3, 0, 0);
		write_edge(63, 63, 5);
		write_edge(0, 2, 0);
		run_from(0);
		run_from(3);
		run_from(5);
		set_vertex_count(127);
		run_from(63);
	endtask

	// random graphs of varied size
	task automatic test_random_graphs(input int target);
		int n;
		while (items_sent < target) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(2, 6);
			set_vertex_count(n);
			for (int k = 0; k < n * n / 2; k++)
				write_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1), random_weight());
			write_edge($urandom_range(0, 63), $urandom_range(0, 63), WB'($urandom));
			run_from($urandom_range(0, n));
			run_from($urandom_range(0, n - 1));
		end
	endtask

	// sender holds off until the unit has delivered everything
	task automatic test_quiesce();
		drain_results();
		run_from(0);
		drain_results();
	endtask

	initial begin
		for (int i = 0; i < NV*NV; i++) begin
			edge_weight_mem[i] = '0;
			edge_written[i] = 0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		rx_enabled = 1'b1;
		@(posedge clk);
		test_directed();
		test_random_graphs(190);
		test_quiesce();
		set_vertex_count(64);
		for (int k = 0; k < 20; k++)
			write_edge($urandom_range(0, 63), $urandom_range(0, 63), random_weight());
		run_from($urandom_range(0, 63));
		drain_results();
		repeat (100) @(posedge clk);
		if (mismatch_count == 0 && expected_paths.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

### sim.f
rtl/sssp_pkg.sv
rtl/sssp_ram.sv
rtl/single_source_shortest_paths_unit.sv
dv/single_source_shortest_paths_unit_tb.sv
